FILE: rtl/pbw_pkg.sv
// ----------------------------------------------------------------------------
// Periodic box wrap package
// Shared widths, register indexes and payload types for the periodic
// boundary wrap pipeline.
// ----------------------------------------------------------------------------
package pbw_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int EXT_WIDTH   = 31;
    localparam int IDX_WIDTH   = 2;

    // Width wide enough to compare a magnitude against an extent.
    localparam int CMP_WIDTH = (COORD_WIDTH > EXT_WIDTH) ? COORD_WIDTH : EXT_WIDTH;

    // Pre stage, one remainder step per coordinate bit, two post stages.
    localparam int STAGES = COORD_WIDTH + 3;

    localparam logic [EXT_WIDTH-1:0] EXTENT_RESET = EXT_WIDTH'(65536);

    localparam logic [IDX_WIDTH-1:0] REG_EXTENT_X = 2'd0;
    localparam logic [IDX_WIDTH-1:0] REG_EXTENT_Y = 2'd1;
    localparam logic [IDX_WIDTH-1:0] REG_EXTENT_Z = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [COORD_WIDTH-1:0] mag_t;
    typedef logic        [EXT_WIDTH-1:0]   extent_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        logic   last_in;
    } in_item_t;

    typedef struct packed {
        coord_t wrapped_x;
        coord_t wrapped_y;
        coord_t wrapped_z;
        logic   last_out;
    } out_item_t;

    typedef struct packed {
        logic neg;
        logic pass;
    } axis_flags_t;

endpackage

FILE: rtl/pbw_pre.sv
// ----------------------------------------------------------------------------
// Periodic box wrap, entry stage
// Takes the magnitude of a coordinate and decides whether it lies inside
// the half extent, or the extent is zero, and passes unchanged.
// ----------------------------------------------------------------------------
module pbw_pre (
    input  logic                  clk,
    input  logic                  en,
    input  pbw_pkg::extent_t      extent,
    input  pbw_pkg::coord_t       pos,
    output pbw_pkg::coord_t       pos_reg,
    output pbw_pkg::mag_t         mag_reg,
    output pbw_pkg::axis_flags_t  flags_reg
);

    localparam int XW = pbw_pkg::CMP_WIDTH;

    pbw_pkg::mag_t        pos_u;
    pbw_pkg::mag_t        mag_next;
    pbw_pkg::axis_flags_t flags_next;
    pbw_pkg::extent_t     half;

    always_comb
    begin
        pos_u    = pbw_pkg::mag_t'(pos);
        half     = extent >> 1;
        flags_next.neg = pos[pbw_pkg::COORD_WIDTH-1];
        // The most negative coordinate has a magnitude that still fits unsigned.
        mag_next = flags_next.neg ? (~pos_u + pbw_pkg::mag_t'(1)) : pos_u;
        flags_next.pass = (extent == '0) || (XW'(mag_next) <= XW'(half));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg   <= pos;
            mag_reg   <= mag_next;
            flags_reg <= flags_next;
        end
    end

endmodule

FILE: rtl/pbw_rem_step.sv
// ----------------------------------------------------------------------------
// Periodic box wrap, remainder step
// One restoring step of the magnitude-modulo-extent reduction: brings in
// the next magnitude bit and subtracts the extent when it fits.
// ----------------------------------------------------------------------------
module pbw_rem_step (
    input  logic                  clk,
    input  logic                  en,
    input  pbw_pkg::extent_t      extent,
    input  pbw_pkg::coord_t       pos_in,
    input  pbw_pkg::mag_t         mag_in,
    input  pbw_pkg::extent_t      rem_in,
    input  pbw_pkg::axis_flags_t  flags_in,
    output pbw_pkg::coord_t       pos_reg,
    output pbw_pkg::mag_t         mag_reg,
    output pbw_pkg::extent_t      rem_reg,
    output pbw_pkg::axis_flags_t  flags_reg
);

    localparam int EW = pbw_pkg::EXT_WIDTH;
    localparam int CW = pbw_pkg::COORD_WIDTH;

    logic [EW:0]      trial;
    logic [EW:0]      ext_x;
    pbw_pkg::extent_t rem_next;
    pbw_pkg::mag_t    mag_next;

    always_comb
    begin
        trial    = {rem_in, mag_in[CW-1]};
        ext_x    = {1'b0, extent};
        rem_next = (trial >= ext_x) ? EW'(trial - ext_x) : trial[EW-1:0];
        mag_next = {mag_in[CW-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg   <= pos_in;
            mag_reg   <= mag_next;
            rem_reg   <= rem_next;
            flags_reg <= flags_in;
        end
    end

endmodule

FILE: rtl/pbw_post.sv
// ----------------------------------------------------------------------------
// Periodic box wrap, exit stages
// Turns the magnitude remainder into the coordinate modulo the extent and
// then recenters it on zero; a coordinate flagged to pass goes out unchanged.
// ----------------------------------------------------------------------------
module pbw_post (
    input  logic                  clk,
    input  logic                  en,
    input  pbw_pkg::extent_t      extent,
    input  pbw_pkg::coord_t       pos_in,
    input  pbw_pkg::extent_t      rem_in,
    input  pbw_pkg::axis_flags_t  flags_in,
    output pbw_pkg::coord_t       wrapped_reg
);

    localparam int EW = pbw_pkg::EXT_WIDTH;
    localparam int CW = pbw_pkg::COORD_WIDTH;
    localparam int TW = pbw_pkg::CMP_WIDTH + 1;

    pbw_pkg::coord_t      pos_a_reg;
    pbw_pkg::axis_flags_t flags_a_reg;
    pbw_pkg::extent_t     q_reg;
    pbw_pkg::extent_t     q_next;

    logic [EW:0]     dbl;
    logic [EW:0]     ext_x;
    logic [TW-1:0]   q_w;
    logic [TW-1:0]   e_w;
    logic [TW-1:0]   h_w;
    logic [TW-1:0]   r_w;
    pbw_pkg::coord_t wrapped_next;

    // A negative coordinate with a nonzero remainder folds back from the extent.
    always_comb
    begin
        q_next = (flags_in.neg && (rem_in != '0)) ? (extent - rem_in) : rem_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_a_reg   <= pos_in;
            flags_a_reg <= flags_in;
            q_reg       <= q_next;
        end
    end

    always_comb
    begin
        dbl   = {q_reg, 1'b0};
        ext_x = {1'b0, extent};
        q_w   = TW'(q_reg);
        e_w   = TW'(extent);
        h_w   = TW'(extent >> 1);
        if (dbl < ext_x)
        begin
            r_w = q_w;
        end
        else if (dbl > ext_x)
        begin
            r_w = q_w - e_w;
        end
        else
        begin
            // Exactly on the half-extent boundary the sign is opposite to the input's.
            r_w = flags_a_reg.neg ? h_w : (TW'(0) - h_w);
        end
        wrapped_next = flags_a_reg.pass ? pos_a_reg : pbw_pkg::coord_t'(r_w[CW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wrapped_reg <= wrapped_next;
        end
    end

endmodule

FILE: rtl/pbw_axis.sv
// ----------------------------------------------------------------------------
// Periodic box wrap, one axis
// Chains the entry stage, one remainder step per coordinate bit and the
// exit stages for a single coordinate.
// ----------------------------------------------------------------------------
module pbw_axis (
    input  logic              clk,
    input  logic              en,
    input  pbw_pkg::extent_t  extent,
    input  pbw_pkg::coord_t   pos,
    output pbw_pkg::coord_t   wrapped
);

    localparam int CW = pbw_pkg::COORD_WIDTH;

    pbw_pkg::coord_t      pos_s   [0:CW];
    pbw_pkg::mag_t        mag_s   [0:CW];
    pbw_pkg::extent_t     rem_s   [0:CW];
    pbw_pkg::axis_flags_t flags_s [0:CW];

    assign rem_s[0] = '0;

    pbw_pre u_pre (
        .clk       (clk),
        .en        (en),
        .extent    (extent),
        .pos       (pos),
        .pos_reg   (pos_s[0]),
        .mag_reg   (mag_s[0]),
        .flags_reg (flags_s[0])
    );

    for (genvar k = 0; k < CW; k++)
    begin : g_step
        pbw_rem_step u_step (
            .clk       (clk),
            .en        (en),
            .extent    (extent),
            .pos_in    (pos_s[k]),
            .mag_in    (mag_s[k]),
            .rem_in    (rem_s[k]),
            .flags_in  (flags_s[k]),
            .pos_reg   (pos_s[k+1]),
            .mag_reg   (mag_s[k+1]),
            .rem_reg   (rem_s[k+1]),
            .flags_reg (flags_s[k+1])
        );
    end

    pbw_post u_post (
        .clk         (clk),
        .en          (en),
        .extent      (extent),
        .pos_in      (pos_s[CW]),
        .rem_in      (rem_s[CW]),
        .flags_in    (flags_s[CW]),
        .wrapped_reg (wrapped)
    );

endmodule

FILE: rtl/periodic_box_position_wrap.sv
// Throughput: one request per cycle unless a held output stalls; the remainder is a chain
// of one-bit restoring steps, one pipeline stage per coordinate bit, on each of the three axes.
// A full output stalls the whole pipeline; a one-entry skid register keeps in_stall registered.
// Reset clears the valid bits and the skid flag and sets all three extents to 1.0.
// ----------------------------------------------------------------------------
// Periodic box position wrap
// Wraps each coordinate of a particle position into a box of configured
// extent centered on zero, one position per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module periodic_box_position_wrap (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  pbw_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output pbw_pkg::out_item_t                   out_data,
    input  logic                                 cfg_wr_en,
    input  logic [pbw_pkg::IDX_WIDTH-1:0]        cfg_index,
    input  logic [pbw_pkg::EXT_WIDTH-1:0]        cfg_data
);

    localparam int NS = pbw_pkg::STAGES;

    pbw_pkg::extent_t  extent_x_reg;
    pbw_pkg::extent_t  extent_y_reg;
    pbw_pkg::extent_t  extent_z_reg;

    logic              skid_full_reg;
    logic              skid_full_next;
    pbw_pkg::in_item_t skid_item_reg;
    pbw_pkg::in_item_t sel_item;
    logic              sel_valid;
    logic              en;

    logic [NS-1:0]     valid_reg;
    logic [NS-1:0]     valid_next;
    logic [NS-1:0]     last_reg;

    pbw_pkg::coord_t   wrapped_x;
    pbw_pkg::coord_t   wrapped_y;
    pbw_pkg::coord_t   wrapped_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extent_x_reg <= pbw_pkg::EXTENT_RESET;
            extent_y_reg <= pbw_pkg::EXTENT_RESET;
            extent_z_reg <= pbw_pkg::EXTENT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pbw_pkg::REG_EXTENT_X: extent_x_reg <= cfg_data;
                pbw_pkg::REG_EXTENT_Y: extent_y_reg <= cfg_data;
                pbw_pkg::REG_EXTENT_Z: extent_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves as a whole unless a finished result is held up.
    always_comb
    begin
        en        = !(valid_reg[NS-1] && out_stall);
        sel_item  = skid_full_reg ? skid_item_reg : in_data;
        sel_valid = skid_full_reg || in_valid;
        skid_full_next = skid_full_reg ? !en : (in_valid && !en);
        valid_next = en ? {valid_reg[NS-2:0], sel_valid} : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && in_valid && !en)
        begin
            skid_item_reg <= in_data;
        end
        if (en)
        begin
            last_reg <= {last_reg[NS-2:0], sel_item.last_in};
        end
    end

    pbw_axis u_axis_x (
        .clk     (clk),
        .en      (en),
        .extent  (extent_x_reg),
        .pos     (sel_item.pos_x),
        .wrapped (wrapped_x)
    );

    pbw_axis u_axis_y (
        .clk     (clk),
        .en      (en),
        .extent  (extent_y_reg),
        .pos     (sel_item.pos_y),
        .wrapped (wrapped_y)
    );

    pbw_axis u_axis_z (
        .clk     (clk),
        .en      (en),
        .extent  (extent_z_reg),
        .pos     (sel_item.pos_z),
        .wrapped (wrapped_z)
    );

    assign in_stall           = skid_full_reg;
    assign out_valid          = valid_reg[NS-1];
    assign out_data.wrapped_x = wrapped_x;
    assign out_data.wrapped_y = wrapped_y;
    assign out_data.wrapped_z = wrapped_z;
    assign out_data.last_out  = last_reg[NS-1];

`ifndef SYNTHESIS
    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(valid_reg[NS-1] && out_stall))
        else $error("skid register filled while the pipeline was moving");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_full_reg && en) |=> !skid_full_reg)
        else $error("skid register not drained when the pipeline advanced");

    a_valid_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("valid bits moved while the pipeline was stalled");

    a_valid_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid_reg[NS-2]) |=> valid_reg[NS-1])
        else $error("request lost between the last two stages");
`endif

endmodule
